>>> rtl/sbdd_pkg.sv
// ============================================================================
// sbdd_pkg
// Shared constants for the signed binary to decimal symbol converter.
// ============================================================================
package sbdd_pkg;

  // Default width of the two's complement input word
  localparam int unsigned WordBitsDefault = 32;

  // Symbol encoding: 0..9 are decimal digits, SymMinus is the minus sign
  localparam int unsigned SymW = 4;
  localparam logic [SymW-1:0] SymMinus = 4'd10;

  // Requests held between the front and the back part
  localparam int unsigned QueueDepth = 2;

endpackage

>>> rtl/signed_binary_to_decimal_digits_core.sv
// ============================================================================
// signed_binary_to_decimal_digits_core
// Reads a word as a two's complement integer and emits its decimal text,
// one symbol per request, most significant first, last symbol marked.
// ============================================================================
//
// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+------------------------------
// in      | input     | in_valid_i/in_ready_o | word_value_i
// out     | output    | out_valid_o/out_ready_i | symbol_o, last_symbol_o
//
// A word is loaded from the queue, passes through a bit-serial shift-add-3
// step for each input bit in the back end, and is then emitted one symbol at
// a time, with each leading zero dropped in a step of its own.
// The front queues two words while the back end works.
// Reset clears the queue, the sequencer and the output valid.
// A stalled output holds the back end at its next symbol; a full queue holds in_ready_o low.
// ============================================================================
module signed_binary_to_decimal_digits_core #(
  parameter int unsigned WORD_BITS = sbdd_pkg::WordBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [WORD_BITS-1:0]      word_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [sbdd_pkg::SymW-1:0] symbol_o,
  output logic                      last_symbol_o
);

  logic                 q_valid;
  logic                 q_neg;
  logic [WORD_BITS-1:0] q_mag;
  logic                 q_pop;

  sbdd_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .word_value_i (word_value_i),
    .q_valid_o    (q_valid),
    .q_neg_o      (q_neg),
    .q_mag_o      (q_mag),
    .q_pop_i      (q_pop)
  );

  sbdd_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_neg_i       (q_neg),
    .q_mag_i       (q_mag),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .symbol_o      (symbol_o),
    .last_symbol_o (last_symbol_o)
  );

endmodule

>>> rtl/sbdd_front.sv
// ============================================================================
// sbdd_front
// Accepts input words, splits each into sign and magnitude, and queues the
// result for the conversion back end.
// ============================================================================
module sbdd_front #(
  parameter int unsigned WORD_BITS = sbdd_pkg::WordBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [WORD_BITS-1:0] word_value_i,
  output logic                 q_valid_o,
  output logic                 q_neg_o,
  output logic [WORD_BITS-1:0] q_mag_o,
  input  logic                 q_pop_i
);

  localparam int unsigned Depth = sbdd_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic                 neg_q [Depth];
  logic [WORD_BITS-1:0] mag_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 push;
  logic                 in_neg;
  logic [WORD_BITS-1:0] in_mag;

  // Classify: sign bit and two's complement magnitude
  assign in_neg = word_value_i[WORD_BITS-1];
  assign in_mag = in_neg ? (~word_value_i + WORD_BITS'(1)) : word_value_i;

  assign in_ready_o = (count_q != CntW'(Depth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != '0);
  assign q_neg_o    = neg_q[rd_ptr_q];
  assign q_mag_o    = mag_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !q_pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push && q_pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the classified request
  always_ff @(posedge clk_i) begin
    if (push) begin
      neg_q[wr_ptr_q] <= in_neg;
      mag_q[wr_ptr_q] <= in_mag;
    end
  end

endmodule

>>> rtl/sbdd_back.sv
// ============================================================================
// sbdd_back
// Bit-serial shift-add-3 conversion of a magnitude to BCD, then emission of
// the sign and the digits, leading zeros dropped, through an output register.
// ============================================================================
module sbdd_back #(
  parameter int unsigned WORD_BITS = sbdd_pkg::WordBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  logic                      q_neg_i,
  input  logic [WORD_BITS-1:0]      q_mag_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [sbdd_pkg::SymW-1:0] symbol_o,
  output logic                      last_symbol_o
);

  // Enough decimal digits for 2^(WORD_BITS-1)
  localparam int unsigned NumDig = (WORD_BITS * 3) / 10 + 1;
  localparam int unsigned BcdW   = NumDig * 4;
  localparam int unsigned CntW   = $clog2(WORD_BITS);
  localparam int unsigned DigW   = $clog2(NumDig);
  localparam int unsigned SymW   = sbdd_pkg::SymW;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StConv  = 2'd1;
  localparam logic [1:0] StSign  = 2'd2;
  localparam logic [1:0] StDigit = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [WORD_BITS-1:0] bin_q, bin_d;
  logic [BcdW-1:0]      bcd_q, bcd_d;
  logic [BcdW-1:0]      bcd_adj;
  logic                 neg_q, neg_d;
  logic                 started_q, started_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DigW-1:0]      dig_q, dig_d;
  logic                 out_valid_q;
  logic [SymW-1:0]      symbol_q;
  logic                 last_q;
  logic                 can_load;
  logic                 load;
  logic [SymW-1:0]      load_sym;
  logic                 load_last;
  logic [3:0]           top_dig;
  logic                 last_dig;

  // Add 3 to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NumDig; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  assign top_dig  = bcd_q[BcdW-1 -: 4];
  assign last_dig = (dig_q == '0);
  assign can_load = !out_valid_q || out_ready_i;

  // Sequence: load, convert, sign, digits
  always_comb begin
    state_d   = state_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    neg_d     = neg_q;
    started_d = started_q;
    cnt_d     = cnt_q;
    dig_d     = dig_q;
    q_pop_o   = 1'b0;
    load      = 1'b0;
    load_sym  = top_dig;
    load_last = 1'b0;
    case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          bin_d   = q_mag_i;
          bcd_d   = '0;
          neg_d   = q_neg_i;
          cnt_d   = '0;
          state_d = StConv;
        end
      end
      StConv: begin
        bcd_d = {bcd_adj[BcdW-2:0], bin_q[WORD_BITS-1]};
        bin_d = {bin_q[WORD_BITS-2:0], 1'b0};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(WORD_BITS - 1)) begin
          dig_d     = DigW'(NumDig - 1);
          started_d = 1'b0;
          state_d   = neg_q ? StSign : StDigit;
        end
      end
      StSign: begin
        if (can_load) begin
          load     = 1'b1;
          load_sym = sbdd_pkg::SymMinus;
          state_d  = StDigit;
        end
      end
      StDigit: begin
        if (top_dig == 4'd0 && !started_q && !last_dig) begin
          // Drop a leading zero without emitting
          bcd_d = {bcd_q[BcdW-5:0], 4'd0};
          dig_d = dig_q - DigW'(1);
        end else if (can_load) begin
          load      = 1'b1;
          load_sym  = top_dig;
          load_last = last_dig;
          started_d = 1'b1;
          bcd_d     = {bcd_q[BcdW-5:0], 4'd0};
          dig_d     = dig_q - DigW'(1);
          if (last_dig) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    neg_q     <= neg_d;
    started_q <= started_d;
    cnt_q     <= cnt_d;
    dig_q     <= dig_d;
    if (load) begin
      symbol_q <= load_sym;
      last_q   <= load_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign symbol_o      = symbol_q;
  assign last_symbol_o = last_q;

endmodule

>>> rtl/sbdd_checker.sv
// ============================================================================
// sbdd_checker
// Port-level checks for the decimal symbol converter, bound to the top level.
// ============================================================================
module sbdd_checker #(
  parameter int unsigned WORD_BITS = sbdd_pkg::WordBitsDefault
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [WORD_BITS-1:0]      word_value_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [sbdd_pkg::SymW-1:0] symbol_o,
  input logic                      last_symbol_o
);

  // Hold a waiting input request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(word_value_i))
    else $error("waiting input request changed");

  // Hold a stalled output request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(symbol_o)
                                    && $stable(last_symbol_o))
    else $error("stalled output request changed");

  // Only digits and the minus sign appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (symbol_o <= sbdd_pkg::SymMinus))
    else $error("symbol code out of range");

  // A minus sign never ends a word's text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (symbol_o == sbdd_pkg::SymMinus) |-> !last_symbol_o)
    else $error("minus sign marked as last symbol");

  // No output request during reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind signed_binary_to_decimal_digits_core sbdd_checker #(.WORD_BITS(WORD_BITS)) u_sbdd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .word_value_i  (word_value_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .symbol_o      (symbol_o),
  .last_symbol_o (last_symbol_o)
);

>>> tb/sv/signed_binary_to_decimal_digits_core_tb.sv
// ============================================================================
// signed_binary_to_decimal_digits_core_tb
// Drives 32-bit words into the converter and checks each decimal symbol it
// returns, sign first and last symbol marked, against expectations that are
// either typed into the directed table or computed from the word's value.
// ============================================================================
module signed_binary_to_decimal_digits_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WordBits    = sbdd_pkg::WordBitsDefault;
  localparam int unsigned SymW        = sbdd_pkg::SymW;
  localparam int          NumDirected = 20;
  localparam int          NumRandom   = 250;
  localparam int          HoldCycles  = 400;
  localparam int          QuietLimit  = 3000;
  localparam int          DrainCycles = 60;

  typedef struct packed {
    logic [SymW-1:0] sym;
    logic            last;
  } dec_symbol_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [WordBits-1:0] word_value_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [SymW-1:0]     symbol_o;
  logic                last_symbol_o;

  // Expected symbols, oldest at the front
  dec_symbol_t expected_syms [$];
  dec_symbol_t head_sym;

  int mismatch_cnt = 0;
  int words_sent   = 0;
  int syms_checked = 0;
  int quiet_cycles = 0;

  // Flow control flags that the main sequence sets for the sender and the receiver
  bit hold_req     = 1'b0;
  bit send_no_idle = 1'b0;
  bit recv_no_idle = 1'b0;

  // Directed table: an empty text means the row is checked by prediction
  logic [WordBits-1:0] dir_words [NumDirected] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0001, 32'h0000_0009, 32'h0000_000A,
    32'hFFFF_FFF6, 32'h3B9A_C9FF, 32'h3B9A_CA00, 32'hC465_3600,
    32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF, 32'hFFFF_0000,
    32'h0000_0064, 32'hFFFF_FF9C, 32'h0000_0010, 32'h7FFF_FFFE
  };
  string dir_text [NumDirected] = '{
    "0", "1", "-1", "2147483647",
    "-2147483648", "-2147483647", "", "",
    "-10", "", "1000000000", "-1000000000",
    "", "", "", "",
    "", "", "", ""
  };

  signed_binary_to_decimal_digits_core #(
    .WORD_BITS(WordBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .word_value_i (word_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .symbol_o     (symbol_o),
    .last_symbol_o(last_symbol_o)
  );

  // Free-running clock, 12 ns period
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Queue the decimal text of a word read as a two's complement integer
  function automatic void queue_decimal_text(input logic [WordBits-1:0] w);
    logic                neg;
    logic [WordBits-1:0] mag;
    logic [SymW-1:0]     digs [24];
    int                  nd;
    dec_symbol_t         s;
    neg = w[WordBits-1];
    mag = neg ? (~w + 1'b1) : w;
    nd  = 0;
    do begin
      digs[nd] = SymW'(mag % 10);
      mag      = mag / 10;
      nd++;
    end while (mag != 0);
    if (neg) begin
      s.sym  = sbdd_pkg::SymMinus;
      s.last = 1'b0;
      expected_syms.push_back(s);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      s.sym  = digs[k];
      s.last = (k == 0);
      expected_syms.push_back(s);
    end
  endfunction

  // Queue a text typed into the directed table
  function automatic void queue_typed_text(input string text);
    dec_symbol_t s;
    for (int i = 0; i < text.len(); i++) begin
      s.sym  = (text[i] == "-") ? sbdd_pkg::SymMinus : SymW'(text[i] - "0");
      s.last = (i == text.len() - 1);
      expected_syms.push_back(s);
    end
  endfunction

  // Mostly no gap, often a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random word biased toward small values, powers of ten and the extremes
  function automatic logic [WordBits-1:0] random_word();
    logic [WordBits-1:0] v;
    logic [WordBits-1:0] p;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 99);
      2: v = '0 - WordBits'($urandom_range(1, 100));
      3: begin
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        v = p + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) v = ~v + 1'b1;
      end
      4: v = $urandom_range(0, 1) ? (32'h7FFF_FFFF - $urandom_range(0, 3))
                                  : (32'h8000_0000 + $urandom_range(0, 3));
      default: begin
        v = $urandom() >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = ~v + 1'b1;
      end
    endcase
    return v;
  endfunction

  // Offer one request and record its expected text once it is accepted
  task automatic offer_word(input logic [WordBits-1:0] w, input string text);
    int gap;
    gap = send_no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    word_value_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (text.len() > 0) queue_typed_text(text);
    else queue_decimal_text(w);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Receiver: random stalls, a stall-free stretch, and one long hold-off
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (recv_no_idle) begin
        out_ready_i <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall - 1) @(negedge clk_i);
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // Compare each accepted symbol with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_syms.size() == 0) begin
        $display("%0t: unexpected symbol %0d last %0b", $realtime, symbol_o, last_symbol_o);
        mismatch_cnt++;
      end else begin
        head_sym = expected_syms.pop_front();
        syms_checked++;
        if (symbol_o !== head_sym.sym) begin
          $display("%0t: symbol mismatch, expected %0d actual %0d",
                   $realtime, head_sym.sym, symbol_o);
          mismatch_cnt++;
        end
        if (last_symbol_o !== head_sym.last) begin
          $display("%0t: last_symbol mismatch, expected %0b actual %0b",
                   $realtime, head_sym.last, last_symbol_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // Abort when no request moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no progress for %0d cycles, %0d symbols outstanding",
               $realtime, QuietLimit, expected_syms.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random words, drain
  initial begin
    in_valid_i   = 1'b0;
    word_value_i = '0;
    rst_ni       = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      offer_word(dir_words[i], dir_text[i]);
    end

    for (int i = 0; i < NumRandom; i++) begin
      // Hold the output while requests keep coming, so the input backs up
      if (i == 100) begin
        hold_req     = 1'b1;
        send_no_idle = 1'b1;
      end
      if (i == 114) send_no_idle = 1'b0;
      // Run both sides without gaps for a while
      if (i == 180) begin
        send_no_idle = 1'b1;
        recv_no_idle = 1'b1;
      end
      if (i == 220) begin
        send_no_idle = 1'b0;
        recv_no_idle = 1'b0;
      end
      offer_word(random_word(), "");
    end
    in_valid_i <= 1'b0;

    wait (expected_syms.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Converted %0d words (%0d from the table, the rest random) into %0d symbols,",
             words_sent, NumDirected, syms_checked);
    $display("with random stalls, a gap-free stretch and a %0d-cycle output hold.",
             HoldCycles);
    if (mismatch_cnt == 0 && expected_syms.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sbdd_pkg.sv
rtl/sbdd_front.sv
rtl/sbdd_back.sv
rtl/signed_binary_to_decimal_digits_core.sv
rtl/sbdd_checker.sv
tb/sv/signed_binary_to_decimal_digits_core_tb.sv
